>>> rtl/core/b64d_pkg.sv
// Package: shared types, widths and character constants of the base64url decoder.
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int COUNT_W  = 16;
    localparam int PEND_W   = 3;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'hFFFF;

    // Alphabet bounds and offsets
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;

    localparam logic [CHAR_W-1:0]   OFS_LOWER = 8'd26;
    localparam logic [CHAR_W-1:0]   OFS_DIGIT = 8'd52;
    localparam logic [SEXTET_W-1:0] VAL_MINUS = 6'd62;
    localparam logic [SEXTET_W-1:0] VAL_UNDER = 6'd63;

    // Pending bit counts
    localparam logic [PEND_W-1:0] PEND_0 = 3'd0;
    localparam logic [PEND_W-1:0] PEND_2 = 3'd2;
    localparam logic [PEND_W-1:0] PEND_4 = 3'd4;
    localparam logic [PEND_W-1:0] PEND_6 = 3'd6;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_SMALL = 2'd2
    } t_status;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] value;
    } t_sextet;

endpackage

`default_nettype wire

>>> rtl/core/b64d_if.sv
// Interfaces: character request channel and result channel.
`default_nettype none

interface b64d_in_if;
    logic                        valid;
    logic                        ready;
    logic [b64d_pkg::CHAR_W-1:0] character;
    logic                        end_of_text;

    modport source (output valid, output character, output end_of_text, input ready);
    modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface b64d_out_if;
    logic                         valid;
    logic                         ready;
    logic [b64d_pkg::CHAR_W-1:0]  data_byte;
    logic                         final_res;
    logic [1:0]                   status;
    logic [b64d_pkg::COUNT_W-1:0] byte_count;

    modport source (output valid, output data_byte, output final_res, output status,
                    output byte_count, input ready);
    modport sink   (input valid, input data_byte, input final_res, input status,
                    input byte_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/base64url_strict_decoder.sv
// Top level: strict base64url decoder, one character per request.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-------------
//  i_req    | in  | character[7:0], end_of_text                   | valid/ready
//  o_res    | out | data_byte[7:0], final_res, status[1:0],       | valid/ready
//           |     | byte_count[15:0]                              |
//  i_cfg_*  | in  | capacity[15:0]                                | write enable
//
// One request per cycle sustained while the output does not stall. A request
// is captured in an input register, decoded by the sextet map and the
// accumulator logic, and any result lands in the output register as it advances.
// Reset (i_rst_n low at a clock edge) clears both valid flags and the string
// state and sets capacity to 65535. A stalled output holds the decode stage,
// which holds the input register; ready falls only then.
`default_nettype none

module base64url_strict_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    b64d_in_if.sink                             i_req,
    b64d_out_if.source                          o_res,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [b64d_pkg::COUNT_W-1:0]   i_cfg_wr_data
);

    // Configuration
    logic [b64d_pkg::COUNT_W-1:0] r_capacity;

    // Input register
    logic                        r_in_valid;
    logic [b64d_pkg::CHAR_W-1:0] r_char;
    logic                        r_eot;

    // Per-string state: at most six bits are ever pending
    logic [b64d_pkg::SEXTET_W-1:0] r_acc,   n_acc;
    logic [b64d_pkg::PEND_W-1:0]   r_pend,  n_pend;
    logic [b64d_pkg::COUNT_W-1:0]  r_count, n_count;
    logic                          r_err,   n_err;

    // Output register
    logic                         r_out_valid, n_out_valid;
    logic [b64d_pkg::CHAR_W-1:0]  r_byte,      n_byte;
    logic                         r_final,     n_final;
    b64d_pkg::t_status            r_status,    n_status;
    logic [b64d_pkg::COUNT_W-1:0] r_res_count, n_res_count;

    b64d_pkg::t_sextet            w_sx;
    logic                         w_advance;
    logic [2*b64d_pkg::SEXTET_W-1:0] w_bits;

    b64d_sextet_map u_map (
        .i_char   (r_char),
        .o_sextet (w_sx)
    );

    // Decode stage moves when it holds a request and the output slot frees up
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    // Pending bits followed by the new sextet
    assign w_bits = {r_acc, w_sx.value};

    always_comb begin
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_count     = r_count;
        n_err       = r_err;
        n_out_valid = 1'b0;
        n_byte      = '0;
        n_final     = 1'b0;
        n_status    = b64d_pkg::ST_OK;
        n_res_count = r_count;
        if (r_eot) begin
            // End marker: report unless an error was already given, then clear
            if (!r_err) begin
                n_out_valid = 1'b1;
                n_final     = 1'b1;
                n_status    = (r_pend == b64d_pkg::PEND_6) ? b64d_pkg::ST_INVALID
                                                           : b64d_pkg::ST_OK;
            end
            n_acc   = '0;
            n_pend  = b64d_pkg::PEND_0;
            n_count = '0;
            n_err   = 1'b0;
        end else if (r_err) begin
            // drop until end marker
        end else if (!w_sx.ok) begin
            n_err       = 1'b1;
            n_out_valid = 1'b1;
            n_final     = 1'b1;
            n_status    = b64d_pkg::ST_INVALID;
        end else begin
            case (r_pend)
                b64d_pkg::PEND_0: begin
                    n_acc  = w_sx.value;
                    n_pend = b64d_pkg::PEND_6;
                end
                b64d_pkg::PEND_2, b64d_pkg::PEND_4, b64d_pkg::PEND_6: begin
                    n_pend = r_pend - b64d_pkg::PEND_2;
                    if (r_count >= r_capacity) begin
                        n_err       = 1'b1;
                        n_out_valid = 1'b1;
                        n_final     = 1'b1;
                        n_status    = b64d_pkg::ST_TOO_SMALL;
                    end else begin
                        n_out_valid = 1'b1;
                        n_count     = r_count + 1'b1;
                        n_res_count = r_count + 1'b1;
                        // byte is the top eight of pend+6 valid bits
                        case (r_pend)
                            b64d_pkg::PEND_2: begin
                                n_byte = w_bits[7:0];
                                n_acc  = '0;
                            end
                            b64d_pkg::PEND_4: begin
                                n_byte = w_bits[9:2];
                                n_acc  = {4'b0, w_bits[1:0]};
                            end
                            default: begin
                                n_byte = w_bits[11:4];
                                n_acc  = {2'b0, w_bits[3:0]};
                            end
                        endcase
                    end
                end
                default: begin
                    // odd counts never occur
                    n_pend = b64d_pkg::PEND_0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= b64d_pkg::CAPACITY_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_char <= i_req.character;
            r_eot  <= i_req.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pend  <= b64d_pkg::PEND_0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (w_advance) begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= n_out_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_out_valid) begin
            r_byte      <= n_byte;
            r_final     <= n_final;
            r_status    <= n_status;
            r_res_count <= n_res_count;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data_byte  = r_byte;
    assign o_res.final_res  = r_final;
    assign o_res.status     = r_status;
    assign o_res.byte_count = r_res_count;

endmodule

`default_nettype wire

>>> rtl/core/b64d_sextet_map.sv
// Character to six-bit value map for the url-safe alphabet.
`default_nettype none

module b64d_sextet_map (
    input  wire logic [b64d_pkg::CHAR_W-1:0] i_char,
    output b64d_pkg::t_sextet                o_sextet
);

    logic [b64d_pkg::CHAR_W-1:0] w_ofs;

    always_comb begin
        w_ofs    = '0;
        o_sextet = '0;
        if (i_char inside {[b64d_pkg::CH_UPPER_A : b64d_pkg::CH_UPPER_Z]}) begin
            w_ofs          = i_char - b64d_pkg::CH_UPPER_A;
            o_sextet.ok    = 1'b1;
            o_sextet.value = w_ofs[b64d_pkg::SEXTET_W-1:0];
        end else if (i_char inside {[b64d_pkg::CH_LOWER_A : b64d_pkg::CH_LOWER_Z]}) begin
            w_ofs          = i_char - b64d_pkg::CH_LOWER_A + b64d_pkg::OFS_LOWER;
            o_sextet.ok    = 1'b1;
            o_sextet.value = w_ofs[b64d_pkg::SEXTET_W-1:0];
        end else if (i_char inside {[b64d_pkg::CH_DIGIT_0 : b64d_pkg::CH_DIGIT_9]}) begin
            w_ofs          = i_char - b64d_pkg::CH_DIGIT_0 + b64d_pkg::OFS_DIGIT;
            o_sextet.ok    = 1'b1;
            o_sextet.value = w_ofs[b64d_pkg::SEXTET_W-1:0];
        end else if (i_char == b64d_pkg::CH_MINUS) begin
            o_sextet.ok    = 1'b1;
            o_sextet.value = b64d_pkg::VAL_MINUS;
        end else if (i_char == b64d_pkg::CH_UNDER) begin
            o_sextet.ok    = 1'b1;
            o_sextet.value = b64d_pkg::VAL_UNDER;
        end
    end

endmodule

`default_nettype wire

>>> verif/base64url_strict_decoder_tb.sv
// Testbench: base64url_strict_decoder, random handshakes checked against a string-level predictor.
`timescale 1ns / 1ps

import b64d_pkg::*;

typedef struct packed {
    logic [CHAR_W-1:0]  data_byte;
    logic               final_res;
    t_status            status;
    logic [COUNT_W-1:0] byte_count;
} t_decoded;

// Tracks the per-string decode state and the results still owed by the block.
class decode_scoreboard;
    logic [COUNT_W-1:0] capacity = CAPACITY_RESET;
    logic [13:0]        acc      = '0;
    logic [PEND_W-1:0]  pend     = PEND_0;
    logic [COUNT_W-1:0] count    = '0;
    bit                 err_seen = 1'b0;
    t_decoded           due[$];
    int                 mismatches = 0;
    int                 data_bytes = 0;
    int                 closings[3] = '{0, 0, 0};

    function void clear_string();
        acc      = '0;
        pend     = PEND_0;
        count    = '0;
        err_seen = 1'b0;
    endfunction

    function bit map_sextet(input logic [CHAR_W-1:0] ch, output logic [SEXTET_W-1:0] v);
        v = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            v = SEXTET_W'(ch - CH_UPPER_A);
            return 1'b1;
        end
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            v = SEXTET_W'(ch - CH_LOWER_A + OFS_LOWER);
            return 1'b1;
        end
        if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            v = SEXTET_W'(ch - CH_DIGIT_0 + OFS_DIGIT);
            return 1'b1;
        end
        if (ch == CH_MINUS) begin
            v = VAL_MINUS;
            return 1'b1;
        end
        if (ch == CH_UNDER) begin
            v = VAL_UNDER;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void owe_closing(input t_status st);
        due.push_back('{data_byte: '0, final_res: 1'b1, status: st, byte_count: count});
    endfunction

    // Called once per accepted request.
    function void note_request(input logic [CHAR_W-1:0] ch, input logic eot);
        logic [SEXTET_W-1:0] v;
        int                  np;
        logic [CHAR_W-1:0]   b;
        if (eot) begin
            // end marker is silent after an error
            if (!err_seen)
                owe_closing(pend >= PEND_6 ? ST_INVALID : ST_OK);
            clear_string();
            return;
        end
        if (err_seen)
            return;
        if (!map_sextet(ch, v)) begin
            err_seen = 1'b1;
            owe_closing(ST_INVALID);
            return;
        end
        acc = {acc[7:0], v};
        np  = int'(pend) + SEXTET_W;
        if (np < 8) begin
            pend = PEND_W'(np);
            acc  = acc & 14'((1 << np) - 1);
            return;
        end
        np   = np - 8;
        pend = PEND_W'(np);
        if (count >= capacity) begin
            err_seen = 1'b1;
            owe_closing(ST_TOO_SMALL);
            return;
        end
        b     = CHAR_W'(acc >> np);
        acc   = acc & 14'((1 << np) - 1);
        count = count + 1'b1;
        due.push_back('{data_byte: b, final_res: 1'b0, status: ST_OK, byte_count: count});
    endfunction

    function void report(input string field, input int e, input int g);
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, e, g);
    endfunction

    function void check_result(input t_decoded got);
        t_decoded exp;
        if (due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: expected none, got byte %0d final %0d status %0d count %0d",
                     $time, got.data_byte, got.final_res, got.status, got.byte_count);
            return;
        end
        exp = due.pop_front();
        if (got.data_byte !== exp.data_byte)   report("data_byte", exp.data_byte, got.data_byte);
        if (got.final_res !== exp.final_res)   report("final_res", exp.final_res, got.final_res);
        if (got.status !== exp.status)         report("status", exp.status, got.status);
        if (got.byte_count !== exp.byte_count) report("byte_count", exp.byte_count, got.byte_count);
        if (exp.final_res)
            closings[exp.status]++;
        else
            data_bytes++;
    endfunction
endclass

module base64url_strict_decoder_tb;

    localparam int PHASE_ITEMS  = 106;   // eight capacity phases, ~850 requests
    localparam int SETTLE       = 6;     // input and output registers plus margin
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side

    // characters outside the alphabet that a sloppy decoder might accept
    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    b64d_in_if  req_if ();
    b64d_out_if res_if ();

    base64url_strict_decoder uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .o_res         (res_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    decode_scoreboard board;

    int requests_sent = 0;
    int phases_run    = 0;
    bit src_steady    = 1'b0;   // when set the sender streams back to back
    bit snk_steady    = 1'b0;   // when set the receiver never stalls
    int idle_cycles   = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Sextet value to its alphabet character.
    function automatic logic [CHAR_W-1:0] alpha_char(input int v);
        if (v < OFS_LOWER) return CH_UPPER_A + CHAR_W'(v);
        if (v < OFS_DIGIT) return CH_LOWER_A + CHAR_W'(v - OFS_LOWER);
        if (v < VAL_MINUS) return CH_DIGIT_0 + CHAR_W'(v - OFS_DIGIT);
        if (v == VAL_MINUS) return CH_MINUS;
        return CH_UNDER;
    endfunction

    // A character the decoder must reject; favors the neighbors of the ranges.
    function automatic logic [CHAR_W-1:0] pick_invalid();
        case ($urandom_range(0, 10))
            0:       return CH_PAD;
            1:       return CH_PLUS;
            2:       return CH_SLASH;
            3:       return CH_UPPER_A - 1'b1;
            4:       return CH_UPPER_Z + 1'b1;
            5:       return CH_LOWER_A - 1'b1;
            6:       return CH_LOWER_Z + 1'b1 + CHAR_W'($urandom_range(0, 4));
            7:       return CH_DIGIT_9 + 1'b1 + CHAR_W'($urandom_range(0, 6));
            8:       return CHAR_W'($urandom_range(8'h80, 8'hFF));
            9:       return CHAR_W'($urandom_range(8'h00, 8'h2C));
            default: return CH_UNDER + 1'b1;
        endcase
    endfunction

    // One request: optional idle gap, then hold valid until the block takes it.
    task automatic push_request(input logic [CHAR_W-1:0] ch, input logic eot);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.character   <= ch;
        req_if.end_of_text <= eot;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        board.note_request(ch, eot);
        requests_sent++;
    endtask

    // End marker; its character field is don't-care, so randomize it.
    task automatic push_end();
        push_request(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_request(s[i], 1'b0);
        push_end();
    endtask

    // Sender goes quiet until the block owes nothing, then lets the pipe settle.
    task automatic drain_pipe();
        req_if.valid <= 1'b0;
        while (board.due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] v);
        drain_pipe();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.capacity = v;
        phases_run++;
    endtask

    // One string of random shape, closed by an end marker.
    task automatic send_random_string();
        int kind;
        int len;
        int bad;
        if ($urandom_range(0, 7) == 0) src_steady = !src_steady;
        if ($urandom_range(0, 7) == 0) snk_steady = !snk_steady;
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
            // well-formed text; occasionally a long one
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                push_request(alpha_char($urandom_range(0, 63)), 1'b0);
        end else if (kind < 88) begin
            // good text broken by one bad character, tail is dropped
            len = $urandom_range(1, 10);
            bad = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++)
                push_request(i == bad ? pick_invalid() : alpha_char($urandom_range(0, 63)),
                             1'b0);
        end else if (kind < 96) begin
            // raw byte noise
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                push_request(CHAR_W'($urandom_range(0, 255)), 1'b0);
        end else begin
            // a run of empty strings
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                push_end();
        end
        push_end();
    endtask

    // Receiver: check every taken result, then decide the next ready.
    initial begin
        t_decoded got;
        int       hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.data_byte  = res_if.data_byte;
                got.final_res  = res_if.final_res;
                got.status     = t_status'(res_if.status);
                got.byte_count = res_if.byte_count;
                board.check_result(got);
            end
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                hold = pick_gap(snk_steady);
            end
        end
    end

    // Watchdog: too long with no handshake on either channel ends the run.
    initial begin
        forever begin
            @(posedge clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, %0d cycles without a handshake", $time, idle_cycles);
                $display("base64url_strict_decoder_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] phase_caps[8];
        int                 phase_start;
        int                 pause_at;
        bit                 paused;

        board = new;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_if.valid       <= 1'b0;
        req_if.character   <= '0;
        req_if.end_of_text <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings at the reset capacity.
        push_end();                 // empty string, ok with zero bytes
        send_text("AA");            // one zero byte, 4 leftover bits unchecked
        send_text("_-9z");          // top of the lower and digit ranges and both symbols, three bytes
        send_text("A");             // dangling six-bit group
        send_text("Z=AB");          // pad character, rest dropped, end silent
        push_request(8'hFF, 1'b0);  // all ones, above ASCII
        push_end();
        send_text("+");             // standard-alphabet characters are rejected
        send_text("/");

        // Capacity extremes: none at all, then exactly one byte.
        write_capacity(16'd0);
        send_text("AA");
        write_capacity(16'd1);
        send_text("AAAA");

        // Random phases over a spread of capacities.
        phase_caps = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd7,
                       COUNT_W'($urandom_range(4, 30)), 16'hFFFF};
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            phase_start = requests_sent;
            pause_at    = $urandom_range(20, 80);
            paused      = 1'b0;
            while (requests_sent - phase_start < PHASE_ITEMS) begin
                // sender holds off mid-phase until all owed results are back
                if (!paused && requests_sent - phase_start >= pause_at) begin
                    drain_pipe();
                    paused = 1'b1;
                end
                send_random_string();
            end
        end

        drain_pipe();

        $display("covered %0d requests across %0d capacity writes", requests_sent, phases_run);
        $display("results: %0d bytes, closings ok %0d / invalid %0d / too-small %0d",
                 board.data_bytes, board.closings[ST_OK], board.closings[ST_INVALID],
                 board.closings[ST_TOO_SMALL]);
        if (board.mismatches == 0 && board.due.size() == 0) begin
            $display("base64url_strict_decoder_tb: done, clean");
        end else begin
            $display("base64url_strict_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule
